FILE: rtl/utf32_to_utf8_encoder_defines.svh
// Assertion helpers shared by the encoder RTL.
`ifndef UTF32_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF32_TO_UTF8_ENCODER_DEFINES_SVH

// Clocked assertion, masked while reset is low.
`define U2U8_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clock and reset names.
`define U2U8_ASSERT(label, prop, msg) \
    `U2U8_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/u2u8_pkg.sv
package u2u8_pkg;

    localparam logic [31:0] MARK_NATIVE  = 32'h0000_FEFF;
    localparam logic [31:0] MARK_SWAPPED = 32'hFFFE_0000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADBOM = 2'd1,
        ST_BIG    = 2'd2
    } t_status;

    // nb is the byte count minus one
    typedef struct packed {
        t_status     status;
        logic [20:0] cp;
        logic [1:0]  nb;
    } t_cmd;

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [1:0] utf8_len(input logic [20:0] cp);
        logic [1:0] nb;
        if (cp < 21'h80) begin
            nb = 2'd0;
        end else if (cp < 21'h800) begin
            nb = 2'd1;
        end else if (cp < 21'h10000) begin
            nb = 2'd2;
        end else begin
            nb = 2'd3;
        end
        return nb;
    endfunction

    function automatic logic [7:0] utf8_byte(input t_cmd c, input logic [1:0] idx);
        logic [1:0]  sh;
        logic [20:0] s;
        logic [7:0]  b;
        sh = c.nb - idx;
        unique case (sh)
            2'd0:    s = c.cp;
            2'd1:    s = c.cp >> 6;
            2'd2:    s = c.cp >> 12;
            default: s = c.cp >> 18;
        endcase
        if (c.status != ST_OK) begin
            b = 8'h00;
        end else if (c.nb == 2'd0) begin
            b = {1'b0, c.cp[6:0]};
        end else if (idx == 2'd0) begin
            unique case (c.nb)
                2'd1:    b = 8'hC0 | {3'b000, s[4:0]};
                2'd2:    b = 8'hE0 | {4'b0000, s[3:0]};
                default: b = 8'hF0 | {5'b00000, s[2:0]};
            endcase
        end else begin
            b = 8'h80 | {2'b00, s[5:0]};
        end
        return b;
    endfunction

endpackage

FILE: rtl/u2u8_ifs.sv
interface u2u8_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        new_stream;

    modport source (output valid, word, new_stream, input ready);
    modport sink   (input valid, word, new_stream, output ready);
endinterface

interface u2u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;

    modport source (output valid, out_byte, last, status, input ready);
    modport sink   (input valid, out_byte, last, status, output ready);
endinterface

FILE: rtl/u2u8_front.sv
module u2u8_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u2u8_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output u2u8_pkg::t_cmd  o_cmd
);
    import u2u8_pkg::*;

    logic        r_order_known, r_swap_order, r_stream_failed;
    logic        n_order_known, n_swap_order, n_stream_failed;
    logic        accept;
    logic        push;
    logic        mark_path;
    logic [31:0] cp;
    t_cmd        cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign mark_path  = i_in.new_stream || (!r_stream_failed && !r_order_known);
    assign cp         = r_swap_order ? byte_reverse(i_in.word) : i_in.word;

    always_comb begin
        n_order_known   = r_order_known;
        n_swap_order    = r_swap_order;
        n_stream_failed = r_stream_failed;
        push            = 1'b0;
        cmd             = '{status: ST_OK, cp: '0, nb: '0};
        if (mark_path) begin
            if (i_in.word == MARK_NATIVE || i_in.word == MARK_SWAPPED) begin
                n_order_known   = 1'b1;
                n_swap_order    = (i_in.word == MARK_SWAPPED);
                n_stream_failed = 1'b0;
            end else begin
                n_order_known   = 1'b0;
                n_swap_order    = 1'b0;
                n_stream_failed = 1'b1;
                push            = 1'b1;
                cmd.status      = ST_BADBOM;
            end
        end else if (r_stream_failed) begin
            push       = 1'b1;
            cmd.status = ST_BADBOM;
        end else begin
            push = 1'b1;
            if (|cp[31:21]) begin
                cmd.status = ST_BIG;
            end else begin
                cmd.cp = cp[20:0];
                cmd.nb = utf8_len(cp[20:0]);
            end
        end
    end

    assign o_push = accept && push;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_known   <= 1'b0;
            r_swap_order    <= 1'b0;
            r_stream_failed <= 1'b0;
        end else if (accept) begin
            r_order_known   <= n_order_known;
            r_swap_order    <= n_swap_order;
            r_stream_failed <= n_stream_failed;
        end
    end

endmodule

FILE: rtl/u2u8_fifo.sv
`include "utf32_to_utf8_encoder_defines.svh"

module u2u8_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u2u8_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output u2u8_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import u2u8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `U2U8_ASSERT(a_count_range, (r_count <= CW'(DEPTH)), "queue count beyond depth")
    `U2U8_ASSERT(a_no_overflow, (!(i_push && o_full)), "push into full queue")
    `U2U8_ASSERT(a_no_underflow, (i_pop |-> o_valid), "pop from empty queue")

endmodule

FILE: rtl/u2u8_back.sv
`include "utf32_to_utf8_encoder_defines.svh"

module u2u8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  u2u8_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    u2u8_out_if.source      o_out
);
    import u2u8_pkg::*;

    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    t_cmd       r_cmd;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    t_status    r_status;

    t_cmd       cur_cmd;
    logic [1:0] cur_idx;
    logic       cur_last;
    logic       can_load;
    logic       fire;

    assign can_load = !r_out_valid || o_out.ready;
    assign cur_cmd  = r_busy ? r_cmd : i_cmd;
    assign cur_idx  = r_busy ? r_idx : 2'd0;
    assign cur_last = (cur_idx == cur_cmd.nb);
    assign fire     = (r_busy || i_valid) && can_load;
    assign o_pop    = !r_busy && i_valid && can_load;

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
            n_busy      = !cur_last;
            n_idx       = cur_idx + 2'd1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (fire) begin
            r_byte   <= utf8_byte(cur_cmd, cur_idx);
            r_last   <= cur_last;
            r_status <= cur_cmd.status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;
    assign o_out.status   = r_status;

    `U2U8_ASSERT(a_err_single, ((r_out_valid && r_status != ST_OK) |-> (r_last && r_byte == 8'h00)), "error transfer not a lone zero byte")
    `U2U8_ASSERT(a_idx_range, (r_busy |-> (r_idx != 2'd0 && r_idx <= r_cmd.nb)), "byte index outside sequence")
    `U2U8_ASSERT(a_busy_multi, (r_busy |-> (r_cmd.status == ST_OK && r_cmd.nb != 2'd0)), "held command is not multi-byte")

endmodule

FILE: rtl/utf32_to_utf8_encoder.sv
// Channel  Dir  Payload                                   Transfer
// i_in     in   word[31:0], new_stream                    valid & ready
// o_out    out  out_byte[7:0], last, status[1:0]          valid & ready
//
// One byte per cycle while o_out is ready; a word gives one per UTF-8 byte or result.
// A byte-order mark that opens a stream produces no transfer.
// A Q_DEPTH-entry command queue lets input stay accepted while bytes drain.
// Input ready drops only when the queue is full; output is a registered stage.
// Reset is synchronous, active low, and clears stream state and the queue.
module utf32_to_utf8_encoder #(
    parameter int Q_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2u8_in_if.sink     i_in,
    u2u8_out_if.source  o_out
);
    import u2u8_pkg::*;

    logic push, full, q_valid, pop;
    t_cmd push_cmd, q_cmd;

    u2u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    u2u8_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    u2u8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
